// ----- rtl/core/pppg_pkg.sv -----
`default_nettype none

package pppg_pkg;

    localparam int PERIOD_TICKS_DEF = 100;
    localparam int SAMPLE_SLOTS     = 1024;

    localparam int MASK_W     = 16;
    localparam int TICK_IN_W  = 7;
    localparam int FRAC_W     = 16;
    localparam int SAMPLE_W   = 10;
    localparam int CDUTY_W    = 6;
    localparam int GOFF_W     = 7;
    localparam int MSAMP_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // calib + shift + group offset, all 7 bit
    localparam int SUM_W      = 9;

    // Q1.15 duty rounding
    localparam int FRAC_SHIFT = 15;
    localparam int ROUND_HALF = 16384;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_GEN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMMON_DUTY    = 3'd0,
        CFG_USE_OWN_DUTY   = 3'd1,
        CFG_GROUP_OFFSET   = 3'd2,
        CFG_EXTRA_MASK     = 3'd3,
        CFG_OUTPUTS_EN     = 3'd4,
        CFG_MARKER_EN      = 3'd5,
        CFG_MARKER_SAMPLES = 3'd6
    } cfg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/core/phased_pulse_pattern_generator.sv -----
// Add request: in_ready stays low after acceptance for 9 modulo steps through the shared
// compare/subtract unit, start, end, read-modify-write of both edge RAMs; if duty is zero,
// it returns to idle after start. Marker adds and adds while outputs are disabled stay idle.
// Generate request: the first pair is read in S_GEN_RD and registered in S_GEN, then one pair
// per cycle while out_ready is high, PERIOD_TICKS/2 rounded up pairs, set by the single read port
// of each edge RAM. Reset restores configuration defaults and marks every edge RAM row empty.
`default_nettype none

module phased_pulse_pattern_generator #(
    parameter int PERIOD_TICKS = pppg_pkg::PERIOD_TICKS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_write,
    input  wire logic [pppg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pppg_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              operation,
    input  wire logic [pppg_pkg::MASK_W-1:0]       pin_mask,
    input  wire logic [pppg_pkg::TICK_IN_W-1:0]    calib_ticks,
    input  wire logic [pppg_pkg::TICK_IN_W-1:0]    shift_ticks,
    input  wire logic [pppg_pkg::FRAC_W-1:0]       duty_fraction,
    input  wire logic                              is_marker,
    input  wire logic [pppg_pkg::SAMPLE_W-1:0]     sample_index,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [pppg_pkg::MASK_W-1:0]       word_even,
    output logic      [pppg_pkg::MASK_W-1:0]       word_odd,
    output logic                                   last
);

    import pppg_pkg::*;

    localparam int TW         = $clog2(PERIOD_TICKS);
    localparam int PW         = $clog2(PERIOD_TICKS + 1);
    localparam int HALF       = PERIOD_TICKS / 2;
    localparam int ROWS       = (PERIOD_TICKS + 1) / 2;
    localparam int RW         = $clog2(ROWS);
    localparam int CW         = SUM_W + PW;
    localparam int KW         = $clog2(SUM_W);
    localparam int MUL_W      = FRAC_W + PW + 1;
    localparam int ROW_W      = 2 * MASK_W;
    localparam bit ODD_PERIOD = (PERIOD_TICKS % 2) == 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_START,
        S_END,
        S_WRITE,
        S_GEN_RD,
        S_GEN
    } state_t;

    state_t              state_reg, state_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [SUM_W-1:0]    rem_reg, rem_next;
    logic [TW-1:0]       start_reg, start_next;
    logic [TW-1:0]       end_reg, end_next;
    logic [PW-1:0]       duty_reg, duty_next;
    logic [MASK_W-1:0]   pin_reg, pin_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [MASK_W-1:0]   level_reg, level_next;
    logic [MASK_W-1:0]   init_level_reg, init_level_next;
    logic [ROWS-1:0]     rise_vld_reg, rise_vld_next;
    logic [ROWS-1:0]     fall_vld_reg, fall_vld_next;

    logic [CDUTY_W-1:0]  common_duty_reg, common_duty_next;
    logic                use_own_reg, use_own_next;
    logic [GOFF_W-1:0]   group_off_reg, group_off_next;
    logic [MASK_W-1:0]   extra_mask_reg, extra_mask_next;
    logic                out_en_reg, out_en_next;
    logic                marker_en_reg, marker_en_next;
    logic [MSAMP_W-1:0]  marker_samples_reg, marker_samples_next;

    logic                out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]   word_even_reg, word_even_next;
    logic [MASK_W-1:0]   word_odd_reg, word_odd_next;
    logic                last_reg, last_next;

    logic [CW-1:0]       cs_a, cs_b, cs_diff;
    logic                cs_ge;

    logic                rise_we, fall_we, rd_re;
    logic [RW-1:0]       rise_waddr, fall_waddr, rise_raddr, fall_raddr;
    logic [ROW_W-1:0]    rise_wdata, fall_wdata, rise_rdata, fall_rdata;
    logic [ROW_W-1:0]    rise_row, fall_row;

    logic [MUL_W-1:0]    prod_w, own_raw, duty_sel;
    logic [MASK_W-1:0]   lvl_e, lvl_o;
    logic                gen_last, gen_load, in_fire, marker_hit;

    pppg_csub #(.W(CW)) u_csub (
        .a    (cs_a),
        .b    (cs_b),
        .ge   (cs_ge),
        .diff (cs_diff)
    );

    pppg_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_rise_ram (
        .clk   (clk),
        .we    (rise_we),
        .waddr (rise_waddr),
        .wdata (rise_wdata),
        .re    (rd_re),
        .raddr (rise_raddr),
        .rdata (rise_rdata)
    );

    pppg_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_fall_ram (
        .clk   (clk),
        .we    (fall_we),
        .waddr (fall_waddr),
        .wdata (fall_wdata),
        .re    (rd_re),
        .raddr (fall_raddr),
        .rdata (fall_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign word_even = word_even_reg;
    assign word_odd  = word_odd_reg;
    assign last      = last_reg;

    // duty in ticks, rounded half up and clamped to half a period
    always_comb
    begin
        prod_w   = MUL_W'(frac_reg) * MUL_W'(HALF) + MUL_W'(ROUND_HALF);
        own_raw  = prod_w >> FRAC_SHIFT;
        duty_sel = use_own_reg ? own_raw : MUL_W'(common_duty_reg);
        if (duty_sel > MUL_W'(HALF))
        begin
            duty_sel = MUL_W'(HALF);
        end
    end

    assign marker_hit = (MSAMP_W'(sample_index) < marker_samples_reg)
                        && (32'(sample_index) < 32'(SAMPLE_SLOTS));

    // one pair of ticks: rises first, then falls
    always_comb
    begin
        rise_row = rise_vld_reg[row_reg] ? rise_rdata : '0;
        fall_row = fall_vld_reg[row_reg] ? fall_rdata : '0;
        lvl_e    = (level_reg | rise_row[MASK_W-1:0]) & ~fall_row[MASK_W-1:0];
        lvl_o    = (lvl_e | rise_row[ROW_W-1:MASK_W]) & ~fall_row[ROW_W-1:MASK_W];
        gen_last = (row_reg == RW'(ROWS - 1));
        gen_load = (state_reg == S_GEN) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next          = state_reg;
        k_next              = k_reg;
        rem_next            = rem_reg;
        start_next          = start_reg;
        end_next            = end_reg;
        duty_next           = duty_reg;
        pin_next            = pin_reg;
        frac_next           = frac_reg;
        row_next            = row_reg;
        level_next          = level_reg;
        init_level_next     = init_level_reg;
        rise_vld_next       = rise_vld_reg;
        fall_vld_next       = fall_vld_reg;
        common_duty_next    = common_duty_reg;
        use_own_next        = use_own_reg;
        group_off_next      = group_off_reg;
        extra_mask_next     = extra_mask_reg;
        out_en_next         = out_en_reg;
        marker_en_next      = marker_en_reg;
        marker_samples_next = marker_samples_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        word_even_next      = word_even_reg;
        word_odd_next       = word_odd_reg;
        last_next           = last_reg;

        cs_a       = '0;
        cs_b       = '0;
        rise_we    = 1'b0;
        fall_we    = 1'b0;
        rd_re      = 1'b0;
        rise_waddr = RW'(start_reg >> 1);
        fall_waddr = RW'(end_reg >> 1);
        rise_raddr = row_reg;
        fall_raddr = row_reg;
        rise_wdata = '0;
        fall_wdata = '0;

        if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_COMMON_DUTY:    common_duty_next    = cfg_data[CDUTY_W-1:0];
                CFG_USE_OWN_DUTY:   use_own_next        = cfg_data[0];
                CFG_GROUP_OFFSET:   group_off_next      = cfg_data[GOFF_W-1:0];
                CFG_EXTRA_MASK:     extra_mask_next     = cfg_data[MASK_W-1:0];
                CFG_OUTPUTS_EN:     out_en_next         = cfg_data[0];
                CFG_MARKER_EN:      marker_en_next      = cfg_data[0];
                CFG_MARKER_SAMPLES: marker_samples_next = cfg_data[MSAMP_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pin_next  = pin_mask;
                    frac_next = duty_fraction;
                    rem_next  = SUM_W'(calib_ticks) + SUM_W'(shift_ticks)
                                + SUM_W'(group_off_reg);
                    k_next    = KW'(SUM_W - 1);
                    if (operation == OP_GEN)
                    begin
                        state_next = S_GEN_RD;
                    end
                    else if (out_en_reg)
                    begin
                        if (is_marker && marker_en_reg)
                        begin
                            if (marker_hit)
                            begin
                                init_level_next = init_level_reg | pin_mask;
                            end
                        end
                        else
                        begin
                            state_next = S_MOD;
                        end
                    end
                end
            end

            // restoring reduction modulo the period, one shifted compare per cycle
            S_MOD:
            begin
                duty_next = PW'(duty_sel);
                cs_a      = CW'(rem_reg);
                cs_b      = CW'(PERIOD_TICKS) << k_reg;
                if (cs_ge)
                begin
                    rem_next = SUM_W'(cs_diff);
                end
                k_next = k_reg - KW'(1);
                if (k_reg == '0)
                begin
                    state_next = S_START;
                end
            end

            S_START:
            begin
                cs_a       = CW'(PERIOD_TICKS);
                cs_b       = CW'(rem_reg);
                start_next = (rem_reg == '0) ? '0 : TW'(cs_diff);
                state_next = (duty_reg == '0) ? S_IDLE : S_END;
            end

            S_END:
            begin
                cs_a       = CW'(start_reg) + CW'(duty_reg);
                cs_b       = CW'(PERIOD_TICKS);
                end_next   = cs_ge ? TW'(cs_diff) : TW'(cs_a);
                rd_re      = 1'b1;
                rise_raddr = RW'(start_reg >> 1);
                fall_raddr = RW'(end_next >> 1);
                state_next = S_WRITE;
            end

            // read-modify-write; an empty row reads as zero
            S_WRITE:
            begin
                rise_we    = 1'b1;
                fall_we    = 1'b1;
                rise_wdata = rise_vld_reg[rise_waddr] ? rise_rdata : '0;
                fall_wdata = fall_vld_reg[fall_waddr] ? fall_rdata : '0;
                if (start_reg[0])
                begin
                    rise_wdata[ROW_W-1:MASK_W] = rise_wdata[ROW_W-1:MASK_W] | pin_reg;
                end
                else
                begin
                    rise_wdata[MASK_W-1:0] = rise_wdata[MASK_W-1:0] | pin_reg;
                end
                if (end_reg[0])
                begin
                    fall_wdata[ROW_W-1:MASK_W] = fall_wdata[ROW_W-1:MASK_W] | pin_reg;
                end
                else
                begin
                    fall_wdata[MASK_W-1:0] = fall_wdata[MASK_W-1:0] | pin_reg;
                end
                rise_vld_next[rise_waddr] = 1'b1;
                fall_vld_next[fall_waddr] = 1'b1;
                // wrapped pulse starts the period high
                if (start_reg >= end_reg)
                begin
                    init_level_next = init_level_reg | pin_reg;
                end
                state_next = S_IDLE;
            end

            S_GEN_RD:
            begin
                rd_re      = 1'b1;
                rise_raddr = '0;
                fall_raddr = '0;
                row_next   = '0;
                level_next = init_level_reg;
                state_next = S_GEN;
            end

            S_GEN:
            begin
                if (gen_load)
                begin
                    out_valid_next = 1'b1;
                    word_even_next = lvl_e | extra_mask_reg;
                    word_odd_next  = (gen_last && ODD_PERIOD) ? '0 : (lvl_o | extra_mask_reg);
                    last_next      = gen_last;
                    level_next     = lvl_o;
                    if (gen_last)
                    begin
                        rise_vld_next   = '0;
                        fall_vld_next   = '0;
                        init_level_next = '0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + RW'(1);
                        rd_re      = 1'b1;
                        rise_raddr = row_reg + RW'(1);
                        fall_raddr = row_reg + RW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            k_reg              <= '0;
            rem_reg            <= '0;
            start_reg          <= '0;
            end_reg            <= '0;
            duty_reg           <= '0;
            pin_reg            <= '0;
            frac_reg           <= '0;
            row_reg            <= '0;
            level_reg          <= '0;
            init_level_reg     <= '0;
            rise_vld_reg       <= '0;
            fall_vld_reg       <= '0;
            common_duty_reg    <= '0;
            use_own_reg        <= 1'b0;
            group_off_reg      <= '0;
            extra_mask_reg     <= '0;
            out_en_reg         <= 1'b0;
            marker_en_reg      <= 1'b1;
            marker_samples_reg <= MSAMP_W'(40);
            out_valid_reg      <= 1'b0;
            word_even_reg      <= '0;
            word_odd_reg       <= '0;
            last_reg           <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            k_reg              <= k_next;
            rem_reg            <= rem_next;
            start_reg          <= start_next;
            end_reg            <= end_next;
            duty_reg           <= duty_next;
            pin_reg            <= pin_next;
            frac_reg           <= frac_next;
            row_reg            <= row_next;
            level_reg          <= level_next;
            init_level_reg     <= init_level_next;
            rise_vld_reg       <= rise_vld_next;
            fall_vld_reg       <= fall_vld_next;
            common_duty_reg    <= common_duty_next;
            use_own_reg        <= use_own_next;
            group_off_reg      <= group_off_next;
            extra_mask_reg     <= extra_mask_next;
            out_en_reg         <= out_en_next;
            marker_en_reg      <= marker_en_next;
            marker_samples_reg <= marker_samples_next;
            out_valid_reg      <= out_valid_next;
            word_even_reg      <= word_even_next;
            word_odd_reg       <= word_odd_next;
            last_reg           <= last_next;
        end
    end

    a_phase_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START) |-> (32'(rem_reg) < 32'(PERIOD_TICKS)))
        else $error("phase not reduced below the period");

    a_end_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (32'(end_reg) < 32'(PERIOD_TICKS)))
        else $error("end tick out of range");

    a_tables_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (gen_load && gen_last) |=>
        (rise_vld_reg == '0 && fall_vld_reg == '0 && init_level_reg == '0))
        else $error("edge tables not cleared after the period");

    a_add_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && operation == OP_ADD) |=> !$rose(out_valid))
        else $error("add request produced a result");

endmodule

`default_nettype wire

// ----- rtl/core/pppg_ram.sv -----
`default_nettype none

module pppg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pppg_csub.sv -----
`default_nettype none

// Shared compare/subtract unit: ge = (a >= b), diff = a - b
module pppg_csub #(
    parameter int W = 17
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              ge,
    output logic      [W-1:0] diff
);

    logic [W:0] wide;

    always_comb
    begin
        wide = {1'b0, a} - {1'b0, b};
        ge   = ~wide[W];
        diff = wide[W-1:0];
    end

endmodule

`default_nettype wire

// ----- tb/tb_phased_pulse_pattern_generator.sv -----
`default_nettype none

module tb_phased_pulse_pattern_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import pppg_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int PERIOD        = PERIOD_TICKS_DEF;
    localparam int HALF          = PERIOD / 2;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 420;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ADD,
        ROW_GEN
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        cfg_idx_t               reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [MASK_W-1:0]      mask;
        logic [TICK_IN_W-1:0]   calib;
        logic [TICK_IN_W-1:0]   steer;
        logic [FRAC_W-1:0]      frac;
        logic                   marker;
        logic [SAMPLE_W-1:0]    sample;
        logic                   fixed_out;
        logic [MASK_W-1:0]      fixed_word;
    } stim_row_t;

    typedef struct packed {
        logic [MASK_W-1:0] even;
        logic [MASK_W-1:0] odd;
        logic              last;
    } word_pair_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic                   operation     = OP_ADD;
    logic [MASK_W-1:0]      pin_mask      = '0;
    logic [TICK_IN_W-1:0]   calib_ticks   = '0;
    logic [TICK_IN_W-1:0]   shift_ticks   = '0;
    logic [FRAC_W-1:0]      duty_fraction = '0;
    logic                   is_marker     = 1'b0;
    logic [SAMPLE_W-1:0]    sample_index  = '0;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic [MASK_W-1:0]      word_even;
    logic [MASK_W-1:0]      word_odd;
    logic                   last;

    // predicted edge tables and level at tick 0
    logic [MASK_W-1:0]      rise_edges [PERIOD];
    logic [MASK_W-1:0]      fall_edges [PERIOD];
    logic [MASK_W-1:0]      start_level;

    // register copies, reset values
    logic [CDUTY_W-1:0]     duty_reg       = '0;
    logic                   own_duty_reg   = 1'b0;
    logic [GOFF_W-1:0]      offset_reg     = '0;
    logic [MASK_W-1:0]      extra_reg      = '0;
    logic                   enable_reg     = 1'b0;
    logic                   marker_en_reg  = 1'b1;
    logic [MSAMP_W-1:0]     marker_len_reg = 11'd40;

    word_pair_t             expected_pairs [$];
    int                     errors       = 0;
    int                     idle_cycles  = 0;
    int                     random_items = 0;
    bit                     calm         = 1'b0;
    bit                     hold_go      = 1'b0;
    bit                     hold_taken   = 1'b0;
    int                     hold_left    = 0;

    phased_pulse_pattern_generator #(
        .PERIOD_TICKS(PERIOD)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .pin_mask     (pin_mask),
        .calib_ticks  (calib_ticks),
        .shift_ticks  (shift_ticks),
        .duty_fraction(duty_fraction),
        .is_marker    (is_marker),
        .sample_index (sample_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .word_even    (word_even),
        .word_odd     (word_odd),
        .last         (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void clear_edges();
        foreach (rise_edges[t])
        begin
            rise_edges[t] = '0;
            fall_edges[t] = '0;
        end
        start_level = '0;
    endfunction

    function automatic void note_transducer(stim_row_t r);
        int unsigned phase;
        int unsigned first;
        int unsigned stop;
        int unsigned duty;
        if (!enable_reg)
            return;
        if (r.marker && marker_en_reg)
        begin
            if (r.sample < marker_len_reg && r.sample < SAMPLE_SLOTS)
                start_level |= r.mask;
            return;
        end
        phase = (32'(r.calib) + 32'(r.steer) + 32'(offset_reg)) % PERIOD;
        first = (PERIOD - phase) % PERIOD;
        if (own_duty_reg)
            duty = (32'(r.frac) * HALF + ROUND_HALF) >> FRAC_SHIFT;
        else
            duty = 32'(duty_reg);
        if (duty > HALF)
            duty = HALF;
        if (duty == 0)
            return;
        stop = (first + duty) % PERIOD;
        rise_edges[first] |= r.mask;
        fall_edges[stop]  |= r.mask;
        // pulse straddles tick 0
        if (first >= stop)
            start_level |= r.mask;
    endfunction

    function automatic void emit_period();
        logic [MASK_W-1:0] level;
        word_pair_t        p;
        level = start_level;
        for (int t = 0; t < PERIOD; t += 2)
        begin
            level  = (level | rise_edges[t]) & ~fall_edges[t];
            p.even = level | extra_reg;
            p.odd  = '0;
            if (t + 1 < PERIOD)
            begin
                level = (level | rise_edges[t + 1]) & ~fall_edges[t + 1];
                p.odd = level | extra_reg;
            end
            p.last = (t + 2 >= PERIOD);
            expected_pairs.push_back(p);
        end
        clear_edges();
    endfunction

    function automatic stim_row_t add_row(logic [MASK_W-1:0] mask, int calib, int steer,
                                          int frac, logic marker, int sample);
        stim_row_t r;
        r        = '0;
        r.kind   = ROW_ADD;
        r.mask   = mask;
        r.calib  = TICK_IN_W'(calib);
        r.steer  = TICK_IN_W'(steer);
        r.frac   = FRAC_W'(frac);
        r.marker = marker;
        r.sample = SAMPLE_W'(sample);
        return r;
    endfunction

    function automatic stim_row_t gen_row(logic fixed_out, logic [MASK_W-1:0] word);
        stim_row_t r;
        r            = '0;
        r.kind       = ROW_GEN;
        r.fixed_out  = fixed_out;
        r.fixed_word = word;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic stim_row_t random_row(logic is_gen);
        stim_row_t r;
        int        pick;
        int        s;
        r      = '0;
        r.kind = is_gen ? ROW_GEN : ROW_ADD;
        pick   = $urandom_range(99);
        if (pick < 50)
            r.mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
        else if (pick < 85)
            r.mask = MASK_W'($urandom);
        else if (pick < 92)
            r.mask = '0;
        else
            r.mask = '1;
        r.calib = ($urandom_range(99) < 85) ? TICK_IN_W'($urandom_range(99))
                                              : TICK_IN_W'($urandom);
        r.steer = ($urandom_range(99) < 85) ? TICK_IN_W'($urandom_range(99))
                                              : TICK_IN_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
            r.frac = FRAC_W'($urandom_range(32768));
        else if (pick < 90)
        begin
            // rounding and saturation boundaries
            case ($urandom_range(5))
                0:       r.frac = 16'd0;
                1:       r.frac = 16'd327;
                2:       r.frac = 16'd328;
                3:       r.frac = 16'd32767;
                4:       r.frac = 16'd32768;
                default: r.frac = 16'd65535;
            endcase
        end
        else
            r.frac = FRAC_W'($urandom);
        r.marker = ($urandom_range(99) < 15);
        if ($urandom_range(1) == 0)
        begin
            s = int'(marker_len_reg) + int'($urandom_range(3)) - 2;
            if (s < 0)
                s = 0;
            if (s > 1023)
                s = 1023;
            r.sample = SAMPLE_W'(s);
        end
        else
            r.sample = SAMPLE_W'($urandom);
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_of(int a, int b, int c, int rnd);
        case ($urandom_range(5))
            0:       return CFG_DATA_W'(a);
            1:       return CFG_DATA_W'(b);
            2:       return CFG_DATA_W'(c);
            default: return CFG_DATA_W'(rnd);
        endcase
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_COMMON_DUTY:    duty_reg       = val[CDUTY_W-1:0];
            CFG_USE_OWN_DUTY:   own_duty_reg   = val[0];
            CFG_GROUP_OFFSET:   offset_reg     = val[GOFF_W-1:0];
            CFG_EXTRA_MASK:     extra_reg      = val[MASK_W-1:0];
            CFG_OUTPUTS_EN:     enable_reg     = val[0];
            CFG_MARKER_EN:      marker_en_reg  = val[0];
            CFG_MARKER_SAMPLES: marker_len_reg = val[MSAMP_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic offer(stim_row_t r);
        cfg_write <= 1'b0;
        while (!calm && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= (r.kind == ROW_GEN) ? OP_GEN : OP_ADD;
        pin_mask      <= r.mask;
        calib_ticks   <= r.calib;
        shift_ticks   <= r.steer;
        duty_fraction <= r.frac;
        is_marker     <= r.marker;
        sample_index  <= r.sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (r.kind == ROW_ADD)
            note_transducer(r);
        else if (r.fixed_out)
        begin
            for (int t = 0; t < PERIOD; t += 2)
                expected_pairs.push_back({r.fixed_word,
                                          (t + 1 < PERIOD) ? r.fixed_word : 16'h0000,
                                          (t + 2 >= PERIOD)});
            clear_edges();
        end
        else
            emit_period();
    endtask

    // drain every pending result, then let a trailing add request finish
    task automatic wait_idle();
        in_valid  <= 1'b0;
        cfg_write <= 1'b0;
        @(posedge clk);
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 36);
        end
    end

    always @(posedge clk)
    begin : check_pairs
        word_pair_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pairs.size() == 0)
            begin
                $error("unexpected result: word_even %h word_odd %h last %b",
                       word_even, word_odd, last);
                errors++;
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (word_even !== want.even)
                begin
                    $error("word_even: expected %h, got %h", want.even, word_even);
                    errors++;
                end
                if (word_odd !== want.odd)
                begin
                    $error("word_odd: expected %h, got %h", want.odd, word_odd);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_phased_pulse_pattern_generator: errors");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t plan [$];
        stim_row_t r;
        bit        busy;
        int        groups;
        int        n_adds;
        int        phase_no;
        busy     = 1'b0;
        phase_no = 0;
        clear_edges();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing recorded after reset: all zero words
        plan.push_back(gen_row(1'b1, 16'h0000));
        // outputs disabled by default: the add is dropped
        plan.push_back(add_row(16'hFFFF, 0, 0, 32768, 1'b0, 0));
        plan.push_back(cfg_row(CFG_EXTRA_MASK, 16'h8001));
        plan.push_back(gen_row(1'b1, 16'h8001));
        plan.push_back(cfg_row(CFG_EXTRA_MASK, 16'h0000));
        plan.push_back(cfg_row(CFG_OUTPUTS_EN, 16'd1));
        // over half a period, saturates
        plan.push_back(cfg_row(CFG_COMMON_DUTY, 16'd63));
        plan.push_back(add_row(16'h0001, 0, 0, 0, 1'b0, 0));
        plan.push_back(add_row(16'h0002, 99, 99, 0, 1'b0, 0));
        plan.push_back(add_row(16'h0004, 127, 127, 0, 1'b0, 0));
        plan.push_back(add_row(16'h8000, 60, 0, 0, 1'b0, 0));
        plan.push_back(add_row(16'h0000, 10, 10, 0, 1'b0, 0));
        // marker: just inside, at and well beyond the marker length
        plan.push_back(add_row(16'h0100, 0, 0, 0, 1'b1, 39));
        plan.push_back(add_row(16'h0200, 0, 0, 0, 1'b1, 40));
        plan.push_back(add_row(16'h0400, 0, 0, 0, 1'b1, 1023));
        plan.push_back(gen_row(1'b0, 16'h0000));
        // zero duty records nothing
        plan.push_back(cfg_row(CFG_COMMON_DUTY, 16'd0));
        plan.push_back(add_row(16'hFFFF, 5, 5, 0, 1'b0, 0));
        plan.push_back(gen_row(1'b1, 16'h0000));
        plan.push_back(cfg_row(CFG_USE_OWN_DUTY, 16'd1));
        plan.push_back(cfg_row(CFG_GROUP_OFFSET, 16'd127));
        plan.push_back(add_row(16'h0010, 3, 4, 0, 1'b0, 0));
        plan.push_back(add_row(16'h0020, 0, 0, 32768, 1'b0, 0));
        plan.push_back(add_row(16'h0040, 50, 0, 65535, 1'b0, 0));
        plan.push_back(add_row(16'h0080, 20, 0, 327, 1'b0, 0));
        plan.push_back(add_row(16'h1000, 26, 47, 328, 1'b0, 0));
        // marker taken as ordinary carrier
        plan.push_back(cfg_row(CFG_MARKER_EN, 16'd0));
        plan.push_back(add_row(16'h0800, 30, 30, 20000, 1'b1, 0));
        plan.push_back(gen_row(1'b0, 16'h0000));
        plan.push_back(cfg_row(CFG_MARKER_EN, 16'd1));
        plan.push_back(cfg_row(CFG_MARKER_SAMPLES, 16'd2047));
        plan.push_back(add_row(16'h2000, 0, 0, 0, 1'b1, 1023));
        plan.push_back(add_row(16'h4000, 99, 0, 16384, 1'b0, 512));
        plan.push_back(gen_row(1'b0, 16'h0000));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (busy)
                begin
                    wait_idle();
                    busy = 1'b0;
                end
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                busy = 1'b1;
                offer(plan[i]);
            end
        end
        wait_idle();

        while (random_items < RANDOM_ITEMS)
        begin
            write_reg(CFG_COMMON_DUTY, pick_of(0, 50, 63, $urandom_range(63)));
            write_reg(CFG_USE_OWN_DUTY, CFG_DATA_W'($urandom_range(1)));
            write_reg(CFG_GROUP_OFFSET, pick_of(0, 99, 127, $urandom_range(99)));
            case ($urandom_range(9))
                0, 1, 2, 3, 4: write_reg(CFG_EXTRA_MASK, 16'h0000);
                5:             write_reg(CFG_EXTRA_MASK, 16'hFFFF);
                default:       write_reg(CFG_EXTRA_MASK, 16'($urandom & $urandom));
            endcase
            write_reg(CFG_OUTPUTS_EN, CFG_DATA_W'($urandom_range(9) != 0));
            write_reg(CFG_MARKER_EN, CFG_DATA_W'($urandom_range(9) < 7));
            write_reg(CFG_MARKER_SAMPLES, pick_of(0, 1024, 2047, $urandom_range(1100)));

            calm   = (phase_no >= 2 && phase_no < 5);
            groups = $urandom_range(3, 1);
            // long receiver hold-off: the block fills and stalls new requests
            if (phase_no == 6)
            begin
                groups  = 3;
                hold_go = 1'b1;
            end
            repeat (groups)
            begin
                n_adds = $urandom_range(12);
                repeat (n_adds)
                begin
                    r = random_row(1'b0);
                    random_items++;
                    offer(r);
                end
                offer(random_row(1'b1));
                random_items++;
            end
            wait_idle();
            phase_no++;
        end

        if (errors == 0)
            $display("tb_phased_pulse_pattern_generator: clean");
        else
            $display("tb_phased_pulse_pattern_generator: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/pppg_pkg.sv
rtl/core/pppg_ram.sv
rtl/core/pppg_csub.sv
rtl/core/phased_pulse_pattern_generator.sv
tb/tb_phased_pulse_pattern_generator.sv
